// ===== design/bhm_pkg.sv =====
package bhm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 16;
    localparam int MAX_ORDER = 8;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int RAD_W   = 12;
    localparam int ORD_W   = 4;
    localparam int GAIN_W  = FRAC_BITS + 1;

    localparam int SQ_W    = 2 * COORD_W;          // one axis delta squared
    localparam int D2_W    = SQ_W + 1;             // sum of both axes
    localparam int CR2_W   = 2 * RAD_W;
    localparam int RATIO_W = INT_BITS + FRAC_BITS;
    localparam int DEN_W   = RATIO_W + 1;
    localparam int NUM_W   = 2 * FRAC_BITS + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_MASK_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_COLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ORDER  = 2'd3;

    localparam logic [DIM_W-1:0] RST_MASK_ROWS     = 13'd256;
    localparam logic [DIM_W-1:0] RST_MASK_COLS     = 13'd256;
    localparam logic [RAD_W-1:0] RST_CUTOFF_RADIUS = 12'd64;
    localparam logic [ORD_W-1:0] RST_FILTER_ORDER  = 4'd2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

    typedef logic [RATIO_W-1:0] t_ratio;

endpackage

// ===== design/bhm_if.sv =====
interface bhm_cfg_if import bhm_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bhm_in_if import bhm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    modport source (output valid, output row_index, output col_index, input ready);
    modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface bhm_out_if import bhm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain;
    modport source (output valid, output gain, input ready);
    modport sink   (input valid, input gain, output ready);
endinterface

// ===== design/bhm_udiv_pipe.sv =====
// Restoring divider, one quotient bit per stage. The high part of the
// dividend (i_rem) must be below the divisor for the quotient to fit QW bits.
module bhm_udiv_pipe #(
    parameter int QW = 32,
    parameter int DW = 25,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_num_lo,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic          s_vld  [QW+1];
    logic [DW-1:0] s_rem  [QW+1];
    logic [QW-1:0] s_lo   [QW+1];
    logic [DW-1:0] s_den  [QW+1];
    logic [SW-1:0] s_side [QW+1];

    assign s_vld[0]  = i_valid;
    assign s_rem[0]  = i_rem;
    assign s_lo[0]   = i_num_lo;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic          r_vld;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_lo;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;
        logic [DW:0]   w_sh;
        logic          w_ge;

        assign w_sh = {s_rem[i], s_lo[i][QW-1]};
        assign w_ge = (w_sh >= {1'b0, s_den[i]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? DW'(w_sh - {1'b0, s_den[i]}) : w_sh[DW-1:0];
                r_lo   <= {s_lo[i][QW-2:0], w_ge};
                r_den  <= s_den[i];
                r_side <= s_side[i];
            end
        end

        assign s_vld[i+1]  = r_vld;
        assign s_rem[i+1]  = r_rem;
        assign s_lo[i+1]   = r_lo;
        assign s_den[i+1]  = r_den;
        assign s_side[i+1] = r_side;
    end

    assign o_valid = s_vld[QW];
    assign o_quot  = s_lo[QW];
    assign o_side  = s_side[QW];

endmodule

// ===== design/butterworth_highpass_mask.sv =====
// Butterworth high-pass mask: one gain sample, U1.16 with 65536 = 1.0, per
// (row, col) transaction. Fully pipelined: one coordinate per clock unless
// the output stalls. Stages: 3 distance stages, a 32-stage ratio divider, 8
// power stages, one prep stage, a 17-stage gain divider and the output
// register. The whole pipeline holds while a result waits on the output.
// Write the registers only while no transaction is in flight; the squared
// cutoff is registered from the cutoff register and settles after it updates.
module butterworth_highpass_mask import bhm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bhm_cfg_if.sink    i_cfg,
    bhm_in_if.sink     i_coord,
    bhm_out_if.source  o_mask
);

    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic [RAD_W-1:0] r_cutoff;
    logic [ORD_W-1:0] r_order;
    logic [CR2_W-1:0] r_cr2;
    logic [ORD_W-1:0] w_n;
    logic             w_en;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= RST_MASK_ROWS;
            r_cols   <= RST_MASK_COLS;
            r_cutoff <= RST_CUTOFF_RADIUS;
            r_order  <= RST_FILTER_ORDER;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MASK_ROWS:     r_rows   <= i_cfg.data;
                REG_MASK_COLS:     r_cols   <= i_cfg.data;
                REG_CUTOFF_RADIUS: r_cutoff <= i_cfg.data[RAD_W-1:0];
                REG_FILTER_ORDER:  r_order  <= i_cfg.data[ORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cr2 <= r_cutoff * r_cutoff;
    end

    assign w_n = (r_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : r_order;

    logic r_out_vld;
    logic [GAIN_W-1:0] r_gain;

    assign w_en           = !r_out_vld || o_mask.ready;
    assign i_coord.ready  = w_en;
    assign o_mask.valid   = r_out_vld;
    assign o_mask.gain    = r_gain;

    // stage 1: axis deltas
    logic               r_v1;
    logic [COORD_W-1:0] r_dr, r_dc;
    logic [COORD_W-1:0] w_cr, w_cc;

    assign w_cr = r_rows[DIM_W-1:1];
    assign w_cc = r_cols[DIM_W-1:1];

    // stage 2: squares; stage 3: squared distance and saturation test
    logic            r_v2, r_v3;
    logic [SQ_W-1:0] r_dr2, r_dc2;
    logic [D2_W-1:0] r_d2;
    logic            r_sat3;
    logic [D2_W-1:0] w_d2;

    assign w_d2 = D2_W'(r_dr2) + D2_W'(r_dc2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_coord.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dr  <= (i_coord.row_index >= w_cr) ? i_coord.row_index - w_cr
                                                 : w_cr - i_coord.row_index;
            r_dc  <= (i_coord.col_index >= w_cc) ? i_coord.col_index - w_cc
                                                 : w_cc - i_coord.col_index;
            r_dr2 <= r_dr * r_dr;
            r_dc2 <= r_dc * r_dc;
            r_d2  <= w_d2;
            // ratio overflows 32 bits iff cr2 >= d2 << 16; covers the centre too
            r_sat3 <= (D2_W'(r_cr2 >> FRAC_BITS) >= w_d2);
        end
    end

    // ratio = (cr2 << 16) / d2
    logic   w_q_vld;
    t_ratio w_q;
    logic   w_q_sat;

    bhm_udiv_pipe #(.QW(RATIO_W), .DW(D2_W), .SW(1)) u_ratio_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_v3),
        .i_rem    (D2_W'(r_cr2 >> FRAC_BITS)),
        .i_num_lo (RATIO_W'({r_cr2, {FRAC_BITS{1'b0}}})),
        .i_den    (r_d2),
        .i_side   (r_sat3),
        .o_valid  (w_q_vld),
        .o_quot   (w_q),
        .o_side   (w_q_sat)
    );

    // power chain: stage 0 holds R^1 (or 1.0 for order zero)
    logic   s_pv  [MAX_ORDER];
    t_ratio s_p   [MAX_ORDER];
    t_ratio s_r   [MAX_ORDER];
    logic   s_ps  [MAX_ORDER];

    logic   r_pv0;
    t_ratio r_p0, r_r0;
    logic   r_ps0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv0 <= 1'b0;
        end else if (w_en) begin
            r_pv0 <= w_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0  <= (w_n == '0) ? RATIO_ONE : w_q;
            r_r0  <= w_q;
            r_ps0 <= w_q_sat;
        end
    end

    assign s_pv[0] = r_pv0;
    assign s_p[0]  = r_p0;
    assign s_r[0]  = r_r0;
    assign s_ps[0] = r_ps0;

    for (genvar k = 1; k < MAX_ORDER; k++) begin : g_pow
        logic   r_vld;
        t_ratio r_p, r_r;
        logic   r_sat;
        logic [2*RATIO_W-1:0] w_prod;
        logic   w_step;

        assign w_prod = (2*RATIO_W)'(s_p[k-1]) * (2*RATIO_W)'(s_r[k-1]);
        assign w_step = (ORD_W'(k) < w_n) && !s_ps[k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (w_en) begin
                r_vld <= s_pv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_r <= s_r[k-1];
                if (w_step) begin
                    r_p   <= w_prod[FRAC_BITS +: RATIO_W];
                    r_sat <= |w_prod[2*RATIO_W-1:FRAC_BITS+RATIO_W];
                end else begin
                    r_p   <= s_p[k-1];
                    r_sat <= s_ps[k-1];
                end
            end
        end

        assign s_pv[k] = r_vld;
        assign s_p[k]  = r_p;
        assign s_r[k]  = r_r;
        assign s_ps[k] = r_sat;
    end

    // gain = (1.0^2 + den/2) / den, den = 1.0 + R^n
    logic             r_gv;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic             r_gsat;
    logic [DEN_W-1:0] w_den;

    assign w_den = DEN_W'(s_p[MAX_ORDER-1]) + DEN_W'(RATIO_ONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (w_en) begin
            r_gv <= s_pv[MAX_ORDER-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_den  <= w_den;
            r_num  <= (NUM_W'(1) << (2*FRAC_BITS)) + NUM_W'(w_den >> 1);
            r_gsat <= s_ps[MAX_ORDER-1];
        end
    end

    logic              w_g_vld;
    logic [GAIN_W-1:0] w_g;
    logic              w_g_sat;

    bhm_udiv_pipe #(.QW(GAIN_W), .DW(DEN_W), .SW(1)) u_gain_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_gv),
        .i_rem    (DEN_W'(r_num >> GAIN_W)),
        .i_num_lo (r_num[GAIN_W-1:0]),
        .i_den    (r_den),
        .i_side   (r_gsat),
        .o_valid  (w_g_vld),
        .o_quot   (w_g),
        .o_side   (w_g_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gain <= w_g_sat ? '0 : w_g;
        end
    end

endmodule
